@@ rtl/tdpe_pkg.sv @@
// Shared types, constants and constant-divisor helpers for the date-part extractor.
// Used by the top level, front end, queue and back end; depends on nothing.
package tdpe_pkg;

    // Field widths of the packed timestamp and of the decoded quotients.
    localparam int W_TS    = 64;
    localparam int W_Q1    = 45;
    localparam int W_Q2    = 28;
    localparam int W_Q3    = 15;
    localparam int W_MICRO = 20;
    localparam int W_SOD   = 17;
    localparam int W_YEAR  = 14;
    localparam int W_WHOLE = 26;
    localparam int W_FRAC  = 20;

    // Radixes of the packed format.
    localparam int DIV_MICRO = 1000000;
    localparam int DIV_SOD   = 100000;
    localparam int DIV_YEAR  = 10000;
    localparam int DIV_TZ    = 27;

    // Calendar years are shifted so that year zero lands on a whole 400-year cycle.
    localparam logic [W_YEAR-1:0] YEAR_SHIFT = 14'd400;

    localparam logic [W_TS-1:0] NULL_PATTERN_RESET = '1;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Part selector codes.
    typedef enum logic [3:0] {
        PART_CENTURY    = 4'd0,
        PART_DAY        = 4'd1,
        PART_DECADE     = 4'd2,
        PART_DOW        = 4'd3,
        PART_DOY        = 4'd4,
        PART_HOUR       = 4'd5,
        PART_USEC       = 4'd6,
        PART_MILLENNIUM = 4'd7,
        PART_MSEC       = 4'd8,
        PART_MINUTE     = 4'd9,
        PART_MONTH      = 4'd10,
        PART_QUARTER    = 4'd11,
        PART_SECOND     = 4'd12,
        PART_WEEK       = 4'd13,
        PART_YEAR       = 4'd14
    } part_t;

    // One decoded item as it leaves the front end.
    typedef struct packed {
        logic [3:0]         cmd;
        logic               is_null;
        logic [W_MICRO-1:0] micro;
        logic [W_SOD-1:0]   sod;
        logic [W_YEAR-1:0]  year;
        logic [4:0]         day;
        logic [4:0]         month;
    } front_rec_t;

    // Division by constants through reciprocal multiplication. Each reciprocal is
    // rounded up with enough fraction bits to be exact over the whole input range.
    function automatic logic [10:0] div60_17(input logic [16:0] x);
        logic [40:0] p;
        p = 41'(x) * 41'(139811);
        return p[33:23];
    endfunction

    function automatic logic [5:0] div60_11(input logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'(2185);
        return p[22:17];
    endfunction

    function automatic logic [7:0] div100_14(input logic [13:0] x);
        logic [28:0] p;
        p = 29'(x) * 29'(20972);
        return p[28:21];
    endfunction

    function automatic logic [4:0] div1000_14(input logic [13:0] x);
        logic [28:0] p;
        p = 29'(x) * 29'(16778);
        return p[28:24];
    endfunction

    function automatic logic [10:0] div10_14(input logic [13:0] x);
        logic [28:0] p;
        p = 29'(x) * 29'(26215);
        return p[28:18];
    endfunction

    function automatic logic [10:0] div1000_20(input logic [19:0] x);
        logic [40:0] p;
        p = 41'(x) * 41'(1073742);
        return p[40:30];
    endfunction

    function automatic logic [2:0] mod7_14(input logic [13:0] x);
        logic [28:0] p;
        logic [13:0] r;
        p = 29'(x) * 29'(18725);
        r = x - 14'(p[28:17]) * 14'd7;
        return r[2:0];
    endfunction

    function automatic logic [6:0] div7_9(input logic [8:0] x);
        logic [18:0] p;
        p = 19'(x) * 19'(586);
        return p[18:12];
    endfunction

    function automatic logic [2:0] mod7_9(input logic [8:0] x);
        logic [8:0] r;
        r = x - 9'(div7_9(x)) * 9'd7;
        return r[2:0];
    endfunction

    // Length of a month in a common year; codes that are no month give zero.
    function automatic logic [4:0] month_days(input logic [4:0] m);
        logic [4:0] d;
        case (m)
            5'd1, 5'd3, 5'd5, 5'd7, 5'd8, 5'd10, 5'd12: d = 5'd31;
            5'd4, 5'd6, 5'd9, 5'd11:                     d = 5'd30;
            5'd2:                                        d = 5'd28;
            default:                                     d = 5'd0;
        endcase
        return d;
    endfunction

    // Days in the months before the given one, common year.
    function automatic logic [8:0] days_before(input logic [4:0] m);
        logic [8:0] d;
        case (m)
            5'd1:    d = 9'd0;
            5'd2:    d = 9'd31;
            5'd3:    d = 9'd59;
            5'd4:    d = 9'd90;
            5'd5:    d = 9'd120;
            5'd6:    d = 9'd151;
            5'd7:    d = 9'd181;
            5'd8:    d = 9'd212;
            5'd9:    d = 9'd243;
            5'd10:   d = 9'd273;
            5'd11:   d = 9'd304;
            5'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/timestamp_date_part_extract.sv @@
// Top level of the SQL date-part extractor: configuration register, front end,
// queue and back end. Depends on tdpe_pkg, tdpe_front, tdpe_queue and tdpe_back.
//
// Usage:
//   cfg_valid/cfg_ready/cfg_data write the null pattern; cfg_ready is always high.
//   Write it only while no item is in flight.
//   s_valid/s_ready take one item (s_cmd, s_timestamp) per transfer; m_valid/m_ready
//   give one result (m_whole, m_fraction_millionths, m_is_null) per item, in order.
//   Throughput is one item per cycle unless the receiver stalls the output. The input
//   transfer edge loads the compare stage, then come 20 divider stages
//   (an estimate and a correction stage per 16-bit quotient chunk, 4 + 3 + 2 + 1
//   chunks), the queue write, and five back-end stages ending in the output register.
//   After reset the pipelines and queue are empty and the null pattern is all ones.
//   When the receiver holds m_ready low the back end holds, the queue fills, and
//   then the front end holds and s_ready drops; nothing is lost. When the receiver
//   resumes, s_ready stays low until the full queue has drained one entry.
module timestamp_date_part_extract #(
    parameter int QUEUE_DEPTH = tdpe_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tdpe_pkg::W_TS-1:0]    cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [3:0]                   s_cmd,
    input  logic [tdpe_pkg::W_TS-1:0]    s_timestamp,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tdpe_pkg::W_WHOLE-1:0] m_whole,
    output logic [tdpe_pkg::W_FRAC-1:0]  m_fraction_millionths,
    output logic                         m_is_null
);

    logic [tdpe_pkg::W_TS-1:0] null_pattern_reg;
    logic                      f_valid, f_ready, b_valid, b_ready;
    tdpe_pkg::front_rec_t      f_rec, b_rec;

    assign cfg_ready = 1'b1;

    // Null pattern register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            null_pattern_reg <= tdpe_pkg::NULL_PATTERN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            null_pattern_reg <= cfg_data;
        end
    end

    tdpe_front u_front (
        .aclk(aclk), .aresetn(aresetn), .null_pattern(null_pattern_reg),
        .in_valid(s_valid), .in_ready(s_ready), .in_cmd(s_cmd), .in_timestamp(s_timestamp),
        .out_valid(f_valid), .out_ready(f_ready), .out_rec(f_rec)
    );

    tdpe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_rec(f_rec),
        .out_valid(b_valid), .out_ready(b_ready), .out_rec(b_rec)
    );

    tdpe_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(b_valid), .in_ready(b_ready), .in_rec(b_rec),
        .out_valid(m_valid), .out_ready(m_ready), .out_whole(m_whole),
        .out_frac(m_fraction_millionths), .out_is_null(m_is_null)
    );

endmodule

@@ rtl/tdpe_cdiv.sv @@
// Pipelined division by a constant, 16 quotient bits per pair of stages: a reciprocal
// estimate, then one compare and subtract. Carries a sideband word alongside; depends on nothing.
module tdpe_cdiv #(
    parameter int W   = 64,
    parameter int DIV = 1000000,
    parameter int SW  = 5
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [W-1:0]             in_num,
    input  logic [SW-1:0]            in_side,
    output logic                     out_valid,
    output logic [W-1:0]             out_quot,
    output logic [$clog2(DIV)-1:0]   out_rem,
    output logic [SW-1:0]            out_side
);

    localparam int RW = $clog2(DIV);
    localparam int K  = 16;
    localparam int NC = (W + K - 1) / K;
    localparam int PW = NC * K;
    localparam int VW = RW + K;
    localparam int MW = K + 1;
    // Reciprocal rounded down; the estimate is then low by at most one.
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << VW) / 64'(DIV));

    logic [PW-1:0] num_w  [NC+1];
    logic [PW-1:0] quo_w  [NC+1];
    logic [RW-1:0] rem_w  [NC+1];
    logic [SW-1:0] side_w [NC+1];
    logic          v_w    [NC+1];

    assign num_w[0]  = PW'(in_num);
    assign quo_w[0]  = '0;
    assign rem_w[0]  = '0;
    assign side_w[0] = in_side;
    assign v_w[0]    = in_valid;

    for (genvar c = 0; c < NC; c++) begin : g_chunk
        logic [VW-1:0]    val;
        logic [VW+MW-1:0] prod;
        logic [VW-1:0]    diff;
        logic             fits;
        logic [K-1:0]     q_fix;
        logic [RW-1:0]    rem_fix;
        logic             va_reg, vb_reg;
        logic [VW-1:0]    vala_reg;
        logic [K-1:0]     qea_reg;
        logic [PW-1:0]    numa_reg, quoa_reg, numb_reg, quob_reg;
        logic [SW-1:0]    sidea_reg, sideb_reg;
        logic [RW-1:0]    remb_reg;

        // Bring down the next chunk and estimate its quotient digit.
        assign val  = {rem_w[c], num_w[c][PW-1 -: K]};
        assign prod = (VW+MW)'(val) * (VW+MW)'(RECIP);

        // Correct the estimate with one compare and subtract.
        assign diff    = vala_reg - VW'(qea_reg) * VW'(DIV);
        assign fits    = (diff >= VW'(DIV));
        assign q_fix   = qea_reg + K'(fits);
        assign rem_fix = fits ? RW'(diff - VW'(DIV)) : diff[RW-1:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                va_reg <= 1'b0;
                vb_reg <= 1'b0;
            end else if (en) begin
                va_reg <= v_w[c];
                vb_reg <= va_reg;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                vala_reg  <= val;
                qea_reg   <= prod[VW +: K];
                numa_reg  <= num_w[c] << K;
                quoa_reg  <= quo_w[c];
                sidea_reg <= side_w[c];
                numb_reg  <= numa_reg;
                quob_reg  <= (quoa_reg << K) | PW'(q_fix);
                remb_reg  <= rem_fix;
                sideb_reg <= sidea_reg;
            end
        end

        assign num_w[c+1]  = numb_reg;
        assign quo_w[c+1]  = quob_reg;
        assign rem_w[c+1]  = remb_reg;
        assign side_w[c+1] = sideb_reg;
        assign v_w[c+1]    = vb_reg;
    end

    assign out_valid = v_w[NC];
    assign out_quot  = quo_w[NC][W-1:0];
    assign out_rem   = rem_w[NC];
    assign out_side  = side_w[NC];

endmodule

@@ rtl/tdpe_front.sv @@
// Front end: takes items, flags the null pattern and splits the packed timestamp
// into its fields. Depends on tdpe_pkg and tdpe_cdiv.
module tdpe_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [tdpe_pkg::W_TS-1:0] null_pattern,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [3:0]                in_cmd,
    input  logic [tdpe_pkg::W_TS-1:0] in_timestamp,
    output logic                      out_valid,
    input  logic                      out_ready,
    output tdpe_pkg::front_rec_t      out_rec
);

    localparam int SW1 = 5;
    localparam int SW2 = SW1 + tdpe_pkg::W_MICRO;
    localparam int SW3 = SW2 + tdpe_pkg::W_SOD;
    localparam int SW4 = SW3 + tdpe_pkg::W_YEAR;

    logic                      en;
    logic                      v0_reg;
    logic [3:0]                cmd0_reg;
    logic                      nul0_reg;
    logic [tdpe_pkg::W_TS-1:0] ts0_reg;

    logic                         v1, v2, v3, v4;
    logic [tdpe_pkg::W_TS-1:0]    q1;
    logic [tdpe_pkg::W_Q1-1:0]    q2;
    logic [tdpe_pkg::W_Q2-1:0]    q3;
    logic [tdpe_pkg::W_Q3-1:0]    q4;
    logic [tdpe_pkg::W_MICRO-1:0] r1;
    logic [tdpe_pkg::W_SOD-1:0]   r2;
    logic [tdpe_pkg::W_YEAR-1:0]  r3;
    logic [SW1-1:0] side1;
    logic [SW2-1:0] side2;
    logic [SW3-1:0] side3;
    logic [SW4-1:0] side4;

    // The whole front moves together; it holds only when its last stage is blocked.
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // Entry stage: compare against the null pattern.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd0_reg <= in_cmd;
            nul0_reg <= (in_timestamp == null_pattern);
            ts0_reg  <= in_timestamp;
        end
    end

    // Microseconds come off first.
    tdpe_cdiv #(.W(tdpe_pkg::W_TS), .DIV(tdpe_pkg::DIV_MICRO), .SW(SW1)) u_div_micro (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v0_reg), .in_num(ts0_reg), .in_side({cmd0_reg, nul0_reg}),
        .out_valid(v1), .out_quot(q1), .out_rem(r1), .out_side(side1)
    );

    // Then the second of the day.
    tdpe_cdiv #(.W(tdpe_pkg::W_Q1), .DIV(tdpe_pkg::DIV_SOD), .SW(SW2)) u_div_sod (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v1), .in_num(q1[tdpe_pkg::W_Q1-1:0]), .in_side({side1, r1}),
        .out_valid(v2), .out_quot(q2), .out_rem(r2), .out_side(side2)
    );

    // Then the year.
    tdpe_cdiv #(.W(tdpe_pkg::W_Q2), .DIV(tdpe_pkg::DIV_YEAR), .SW(SW3)) u_div_year (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v2), .in_num(q2[tdpe_pkg::W_Q2-1:0]), .in_side({side2, r2}),
        .out_valid(v3), .out_quot(q3), .out_rem(r3), .out_side(side3)
    );

    // The time zone is dropped; what is left is month*32+day.
    tdpe_cdiv #(.W(tdpe_pkg::W_Q3), .DIV(tdpe_pkg::DIV_TZ), .SW(SW4)) u_div_tz (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v3), .in_num(q3[tdpe_pkg::W_Q3-1:0]), .in_side({side3, r3}),
        .out_valid(v4), .out_quot(q4), .out_rem(), .out_side(side4)
    );

    // Sideband layout from the top: cmd, null flag, micro, second of day, year.
    assign out_valid       = v4;
    assign out_rec.cmd     = side4[SW4-1 -: 4];
    assign out_rec.is_null = side4[SW4-5];
    assign out_rec.micro   = side4[SW4-SW1-1 -: tdpe_pkg::W_MICRO];
    assign out_rec.sod     = side4[SW4-SW2-1 -: tdpe_pkg::W_SOD];
    assign out_rec.year    = side4[tdpe_pkg::W_YEAR-1:0];
    assign out_rec.day     = q4[4:0];
    assign out_rec.month   = q4[9:5];

endmodule

@@ rtl/tdpe_queue.sv @@
// Short queue of decoded items between front and back end.
// Depends on tdpe_pkg for the item record.
module tdpe_queue #(
    parameter int DEPTH = tdpe_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tdpe_pkg::front_rec_t in_rec,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tdpe_pkg::front_rec_t out_rec
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    tdpe_pkg::front_rec_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_rec   = mem_reg[rd_ptr_reg];

    // Pointers wrap at the depth.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_rec;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");
    a_pop_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> count_reg == $past(count_reg) - CW'(1))
        else $error("queue count did not drop on a transfer out");
`endif

endmodule

@@ rtl/tdpe_back.sv @@
// Back end: calendar arithmetic, part selection and the output register.
// Depends on tdpe_pkg for the item record, selector codes and divider helpers.
module tdpe_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  tdpe_pkg::front_rec_t         in_rec,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tdpe_pkg::W_WHOLE-1:0] out_whole,
    output logic [tdpe_pkg::W_FRAC-1:0]  out_frac,
    output logic                         out_is_null
);

    // Fields that ride along unchanged.
    typedef struct packed {
        logic [3:0]  cmd;
        logic        nul;
        logic [19:0] micro;
        logic [13:0] year;
        logic [4:0]  day;
        logic [4:0]  month;
        logic [7:0]  cent;
        logic [4:0]  mill;
        logic [10:0] dec;
    } carry_t;

    typedef struct packed {
        carry_t      c;
        logic [16:0] sod;
        logic        bad_month;
        logic [13:0] ys;
        logic [13:0] y1;
        logic [13:0] y2;
        logic [7:0]  q100_0;
        logic [7:0]  q100_1;
        logic [7:0]  q100_2;
        logic [10:0] q60;
        logic [10:0] ms_q;
    } s1_t;

    typedef struct packed {
        carry_t      c;
        logic        bad_month;
        logic [10:0] q60;
        logic [5:0]  sec;
        logic [5:0]  q3600;
        logic        leap0;
        logic        leap1;
        logic [13:0] e0;
        logic [13:0] e1;
        logic [10:0] ms_q;
        logic [9:0]  ms_r;
        logic [4:0]  dim;
        logic [8:0]  dbm;
    } s2_t;

    typedef struct packed {
        carry_t      c;
        logic        bad;
        logic [5:0]  sec;
        logic [5:0]  minute;
        logic [5:0]  hour;
        logic [8:0]  doy;
        logic [25:0] usec;
        logic [15:0] msec;
        logic [19:0] msfrac;
    } s3_t;

    typedef struct packed {
        s3_t        b;
        logic [2:0] wd;
        logic       w53_0;
        logic       w53_1;
    } s4_t;

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    s4_t  s4_reg, s4_next;
    logic [2:0] j0_reg, j0_next, j1_reg, j1_next;
    logic       leap0_reg, leap1_reg;

    logic [tdpe_pkg::W_WHOLE-1:0] whole_reg, whole_next;
    logic [tdpe_pkg::W_FRAC-1:0]  frac_reg, frac_next;
    logic                         null_reg, null_next;

    assign en       = !v5_reg || out_ready;
    assign in_ready = en;

    // Stage 1: year shifts, divisions by 100, century, millennium and decade, time and millisecond quotients.
    always_comb begin
        logic [13:0] ys;
        ys = in_rec.year + tdpe_pkg::YEAR_SHIFT;
        s1_next.c.cmd   = in_rec.cmd;
        s1_next.c.nul   = in_rec.is_null;
        s1_next.c.micro = in_rec.micro;
        s1_next.c.year  = in_rec.year;
        s1_next.c.day   = in_rec.day;
        s1_next.c.month = in_rec.month;
        s1_next.c.cent  = (in_rec.year == '0) ? 8'd1
                        : tdpe_pkg::div100_14(in_rec.year - 14'd1) + 8'd1;
        s1_next.c.mill  = (in_rec.year == '0) ? 5'd1
                        : tdpe_pkg::div1000_14(in_rec.year - 14'd1) + 5'd1;
        s1_next.c.dec   = tdpe_pkg::div10_14(in_rec.year);
        s1_next.sod       = in_rec.sod;
        s1_next.bad_month = (in_rec.month == 5'd0) || (in_rec.month > 5'd12);
        s1_next.ys        = ys;
        s1_next.y1        = ys - 14'd1;
        s1_next.y2        = ys - 14'd2;
        s1_next.q100_0    = tdpe_pkg::div100_14(ys);
        s1_next.q100_1    = tdpe_pkg::div100_14(ys - 14'd1);
        s1_next.q100_2    = tdpe_pkg::div100_14(ys - 14'd2);
        s1_next.q60       = tdpe_pkg::div60_17(in_rec.sod);
        s1_next.ms_q      = tdpe_pkg::div1000_20(in_rec.micro);
    end

    // Stage 2: leap years, Jan 1 weekday sums, seconds, month tables.
    always_comb begin
        logic [6:0] r100_0;
        logic [6:0] r100_1;
        logic       leap0;
        r100_0 = 7'(s1_reg.ys - 14'(s1_reg.q100_0) * 14'd100);
        r100_1 = 7'(s1_reg.y1 - 14'(s1_reg.q100_1) * 14'd100);
        leap0  = (s1_reg.ys[1:0] == 2'b00 && r100_0 != 7'd0)
              || (r100_0 == 7'd0 && s1_reg.q100_0[1:0] == 2'b00);
        s2_next.c         = s1_reg.c;
        s2_next.bad_month = s1_reg.bad_month;
        s2_next.q60       = s1_reg.q60;
        s2_next.sec       = 6'(s1_reg.sod - 17'(s1_reg.q60) * 17'd60);
        s2_next.q3600     = tdpe_pkg::div60_11(s1_reg.q60);
        s2_next.leap0     = leap0;
        s2_next.leap1     = (s1_reg.y1[1:0] == 2'b00 && r100_1 != 7'd0)
                         || (r100_1 == 7'd0 && s1_reg.q100_1[1:0] == 2'b00);
        // Weekday of Jan 1 counts 365 days a year plus the leap days before it.
        s2_next.e0 = s1_reg.ys + (s1_reg.y1 >> 2) - 14'(s1_reg.q100_1)
                   + 14'(s1_reg.q100_1 >> 2) + 14'd6;
        s2_next.e1 = s1_reg.y1 + (s1_reg.y2 >> 2) - 14'(s1_reg.q100_2)
                   + 14'(s1_reg.q100_2 >> 2) + 14'd6;
        s2_next.ms_q = s1_reg.ms_q;
        s2_next.ms_r = 10'(s1_reg.c.micro - 20'(s1_reg.ms_q) * 20'd1000);
        s2_next.dim  = tdpe_pkg::month_days(s1_reg.c.month)
                     + 5'(leap0 && s1_reg.c.month == 5'd2);
        s2_next.dbm  = tdpe_pkg::days_before(s1_reg.c.month);
    end

    // Stage 3: Jan 1 weekdays, date check, day of year, time parts.
    always_comb begin
        j0_next = tdpe_pkg::mod7_14(s2_reg.e0);
        j1_next = tdpe_pkg::mod7_14(s2_reg.e1);
        s3_next.c      = s2_reg.c;
        s3_next.bad    = s2_reg.bad_month || (s2_reg.c.day == 5'd0)
                      || (s2_reg.c.day > s2_reg.dim);
        s3_next.sec    = s2_reg.sec;
        s3_next.minute = 6'(s2_reg.q60 - 11'(s2_reg.q3600) * 11'd60);
        s3_next.hour   = (s2_reg.q3600 >= 6'd24) ? s2_reg.q3600 - 6'd24 : s2_reg.q3600;
        s3_next.doy    = s2_reg.dbm + 9'(s2_reg.c.day)
                       + 9'(s2_reg.leap0 && s2_reg.c.month > 5'd2);
        s3_next.usec   = 26'(s2_reg.sec) * 26'd1000000 + 26'(s2_reg.c.micro);
        s3_next.msec   = 16'(s2_reg.sec) * 16'd1000 + 16'(s2_reg.ms_q);
        s3_next.msfrac = 20'(s2_reg.ms_r) * 20'd1000;
    end

    // Stage 4: ISO weekday and which years have 53 weeks.
    always_comb begin
        s4_next.b     = s3_reg;
        s4_next.wd    = tdpe_pkg::mod7_9(9'(j0_reg) + s3_reg.doy - 9'd1) + 3'd1;
        s4_next.w53_0 = (j0_reg == 3'd3) || (j0_reg == 3'd2 && leap0_reg);
        s4_next.w53_1 = (j1_reg == 3'd3) || (j1_reg == 3'd2 && leap1_reg);
    end

    // Stage 5: week number and part selection into the output register.
    always_comb begin
        logic [6:0] wk;
        logic [6:0] week;
        logic       unknown;
        s3_t        b;
        b       = s4_reg.b;
        wk      = tdpe_pkg::div7_9(b.doy + 9'd10 - 9'(s4_reg.wd));
        unknown = 1'b0;
        frac_next = '0;
        if (wk == 7'd0) begin
            week = s4_reg.w53_1 ? 7'd53 : 7'd52;
        end else if (wk == 7'd53 && !s4_reg.w53_0) begin
            week = 7'd1;
        end else begin
            week = wk;
        end
        case (tdpe_pkg::part_t'(b.c.cmd))
            tdpe_pkg::PART_CENTURY:    whole_next = 26'(b.c.cent);
            tdpe_pkg::PART_DAY:        whole_next = 26'(b.c.day);
            tdpe_pkg::PART_DECADE:     whole_next = 26'(b.c.dec);
            tdpe_pkg::PART_DOW:        whole_next = (s4_reg.wd == 3'd7) ? '0 : 26'(s4_reg.wd);
            tdpe_pkg::PART_DOY:        whole_next = 26'(b.doy);
            tdpe_pkg::PART_HOUR:       whole_next = 26'(b.hour);
            tdpe_pkg::PART_USEC:       whole_next = b.usec;
            tdpe_pkg::PART_MILLENNIUM: whole_next = 26'(b.c.mill);
            tdpe_pkg::PART_MSEC: begin
                whole_next = 26'(b.msec);
                frac_next  = b.msfrac;
            end
            tdpe_pkg::PART_MINUTE:     whole_next = 26'(b.minute);
            tdpe_pkg::PART_MONTH:      whole_next = 26'(b.c.month);
            tdpe_pkg::PART_QUARTER: begin
                if (b.c.month inside {[5'd1:5'd3]}) begin
                    whole_next = 26'd1;
                end else if (b.c.month inside {[5'd4:5'd6]}) begin
                    whole_next = 26'd2;
                end else if (b.c.month inside {[5'd7:5'd9]}) begin
                    whole_next = 26'd3;
                end else begin
                    whole_next = 26'd4;
                end
            end
            tdpe_pkg::PART_SECOND: begin
                whole_next = 26'(b.sec);
                frac_next  = b.c.micro;
            end
            tdpe_pkg::PART_WEEK:       whole_next = 26'(week);
            tdpe_pkg::PART_YEAR:       whole_next = 26'(b.c.year);
            default: begin
                whole_next = '0;
                unknown    = 1'b1;
            end
        endcase
        null_next = b.c.nul || b.bad || unknown;
        if (null_next) begin
            whole_next = '0;
            frac_next  = '0;
        end
    end

    // Valid bits of the five stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Stage data.
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg    <= s1_next;
            s2_reg    <= s2_next;
            s3_reg    <= s3_next;
            j0_reg    <= j0_next;
            j1_reg    <= j1_next;
            leap0_reg <= s2_reg.leap0;
            leap1_reg <= s2_reg.leap1;
            s4_reg    <= s4_next;
            whole_reg <= whole_next;
            frac_reg  <= frac_next;
            null_reg  <= null_next;
        end
    end

    assign out_valid   = v5_reg;
    assign out_whole   = whole_reg;
    assign out_frac    = frac_reg;
    assign out_is_null = null_reg;

`ifndef ASSERT_OFF
    a_null_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_is_null) |-> (out_whole == '0 && out_frac == '0))
        else $error("null result carries a value");
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_whole <= 26'd59999999 && out_frac <= 20'd999999))
        else $error("result out of range");
`endif

endmodule

@@ test/timestamp_date_part_extract_tb.sv @@
// Self-checking testbench for the SQL date-part extractor.
// It predicts every result from the packed timestamp and the null pattern, and
// depends only on tdpe_pkg and the timestamp_date_part_extract RTL.
module timestamp_date_part_extract_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tdpe_pkg::*;

    localparam int WATCHDOG_CYCLES = 5000;
    localparam int DRAIN_CYCLES    = 200;
    localparam int STALL_CYCLES    = 600;

    typedef struct {
        logic [W_WHOLE-1:0] whole;
        logic [W_FRAC-1:0]  frac;
        logic               is_null;
    } date_part_t;

    // Predicts date parts and holds the results still owed by the block.
    class date_part_scoreboard;
        logic [W_TS-1:0] null_pattern = NULL_PATTERN_RESET;
        date_part_t      owed[$];
        int              errors = 0;

        function bit is_leap(int unsigned y);
            return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
        endfunction

        // ISO weekday of January 1 (Monday is 1) of a shifted year.
        function int unsigned jan1_iso_day(int unsigned y);
            int unsigned p;
            int unsigned d;
            p = y - 1;
            d = 365 * y + p / 4 - p / 100 + p / 400 + 1;
            return (d + 5) % 7 + 1;
        endfunction

        function int unsigned weeks_in(int unsigned y);
            int unsigned j;
            j = jan1_iso_day(y);
            return (j == 4 || (j == 3 && is_leap(y))) ? 53 : 52;
        endfunction

        function date_part_t extract(logic [3:0] cmd, logic [W_TS-1:0] ts);
            date_part_t r;
            longint unsigned t, mon;
            int unsigned micro, sod, sec, yr, dy, m, ys, dim, doy, wd, wk;
            int unsigned lengths[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
            int unsigned month_start[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                             304, 334};
            r.whole = '0;
            r.frac = '0;
            r.is_null = 1'b1;
            if (ts == null_pattern || cmd > PART_YEAR) return r;
            micro = ts % 1000000;
            t = ts / 1000000;
            sod = t % 100000;
            sec = sod % 60;
            t = t / 100000;
            yr = t % 10000;
            t = t / 10000 / 27;
            dy = t % 32;
            mon = t / 32;
            if (mon < 1 || mon > 12) return r;
            m = mon;
            ys = yr + 400;
            dim = lengths[m-1] + ((is_leap(ys) && m == 2) ? 1 : 0);
            if (dy < 1 || dy > dim) return r;
            doy = month_start[m-1] + dy + ((is_leap(ys) && m > 2) ? 1 : 0);
            wd = (jan1_iso_day(ys) - 1 + doy - 1) % 7 + 1;
            wk = (doy + 10 - wd) / 7;
            if (wk == 0) wk = weeks_in(ys - 1);
            else if (wk == 53 && weeks_in(ys) == 52) wk = 1;
            r.is_null = 1'b0;
            case (part_t'(cmd))
                PART_CENTURY:    r.whole = (yr == 0) ? 1 : (yr - 1) / 100 + 1;
                PART_DAY:        r.whole = dy;
                PART_DECADE:     r.whole = yr / 10;
                PART_DOW:        r.whole = wd % 7;
                PART_DOY:        r.whole = doy;
                PART_HOUR:       r.whole = (sod / 3600) % 24;
                PART_USEC:       r.whole = sec * 1000000 + micro;
                PART_MILLENNIUM: r.whole = (yr == 0) ? 1 : (yr - 1) / 1000 + 1;
                PART_MSEC: begin
                    r.whole = sec * 1000 + micro / 1000;
                    r.frac = (micro % 1000) * 1000;
                end
                PART_MINUTE:     r.whole = (sod / 60) % 60;
                PART_MONTH:      r.whole = m;
                PART_QUARTER:    r.whole = (m - 1) / 3 + 1;
                PART_SECOND: begin
                    r.whole = sec;
                    r.frac = micro;
                end
                PART_WEEK:       r.whole = wk;
                default:         r.whole = yr;
            endcase
            return r;
        endfunction

        function void note_input(logic [3:0] cmd, logic [W_TS-1:0] ts);
            owed.push_back(extract(cmd, ts));
        endfunction

        function void check_result(logic [W_WHOLE-1:0] whole, logic [W_FRAC-1:0] frac,
                                   logic is_null);
            date_part_t e;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result whole=%0d frac=%0d null=%0b",
                         $time, whole, frac, is_null);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (whole !== e.whole) begin
                $display("%0t: whole expected %0d actual %0d", $time, e.whole, whole);
                errors++;
            end
            if (frac !== e.frac) begin
                $display("%0t: fraction expected %0d actual %0d", $time, e.frac, frac);
                errors++;
            end
            if (is_null !== e.is_null) begin
                $display("%0t: null flag expected %0b actual %0b", $time, e.is_null, is_null);
                errors++;
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [W_TS-1:0]     cfg_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [3:0]          s_cmd = '0;
    logic [W_TS-1:0]     s_timestamp = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [W_WHOLE-1:0]  m_whole;
    logic [W_FRAC-1:0]   m_fraction_millionths;
    logic                m_is_null;

    date_part_scoreboard sb = new();
    bit idling_on = 1'b1;
    bit stall_request = 1'b0;
    int quiet_cycles = 0;

    always #6 aclk = ~aclk;

    timestamp_date_part_extract u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_timestamp(s_timestamp),
        .m_valid(m_valid), .m_ready(m_ready), .m_whole(m_whole),
        .m_fraction_millionths(m_fraction_millionths), .m_is_null(m_is_null)
    );

    // Observe transfers on all three channels; values are those before the edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.null_pattern = cfg_data;
            if (s_valid && s_ready) sb.note_input(s_cmd, s_timestamp);
            if (m_valid && m_ready) sb.check_result(m_whole, m_fraction_millionths, m_is_null);
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Result receiver: random stall bursts, and one long hold-off on request.
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (stall_request) begin
                m_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge aclk);
                stall_request = 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    function automatic logic [W_TS-1:0] pack_ts(longint unsigned month, longint unsigned day,
                                                longint unsigned tz, longint unsigned year,
                                                longint unsigned sod, longint unsigned micro);
        return ((((month * 32 + day) * 27 + tz) * 10000 + year) * 100000 + sod) * 1000000
               + micro;
    endfunction

    task automatic send_item(logic [3:0] cmd, logic [W_TS-1:0] ts);
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_timestamp <= ts;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    // Registers change only with nothing in flight.
    task automatic write_null_pattern(logic [W_TS-1:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (170) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random(int count);
        logic [W_TS-1:0] ts;
        int unsigned pick;
        repeat (count) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                ts = pack_ts($urandom_range(1, 2), $urandom_range(0, 31), $urandom_range(0, 26),
                             $urandom_range(0, 9999), $urandom_range(0, 99999),
                             $urandom_range(0, 999999));
            else if (pick == 7)
                ts = {$urandom(), $urandom()};
            else if (pick == 8)
                ts = sb.null_pattern;
            else
                ts = pack_ts(0, $urandom_range(0, 31), $urandom_range(0, 26),
                             $urandom_range(0, 9999), $urandom_range(0, 99999),
                             $urandom_range(0, 999999));
            send_item($urandom_range(0, 15), ts);
        end
    endtask

    initial begin
        logic [W_TS-1:0] base;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every selector on one date, then calendar and field extremes.
        base = pack_ts(2, 29, 26, 2024, 45296, 123456);
        for (int c = 0; c <= 15; c++) send_item(c[3:0], base);
        send_item(PART_CENTURY, pack_ts(1, 1, 0, 0, 0, 0));
        send_item(PART_MILLENNIUM, pack_ts(1, 1, 0, 0, 0, 0));
        send_item(PART_WEEK, pack_ts(1, 1, 0, 9999, 99999, 999999));
        send_item(PART_HOUR, pack_ts(1, 31, 0, 1999, 99999, 0));
        send_item(PART_DAY, pack_ts(2, 29, 0, 1900, 0, 0));
        send_item(PART_DAY, pack_ts(1, 0, 0, 2000, 0, 0));
        send_item(PART_MSEC, pack_ts(2, 28, 13, 2021, 86399, 999999));
        send_item(PART_YEAR, '1);
        send_item(PART_YEAR, '0);

        write_null_pattern('0);
        send_item(PART_YEAR, '0);
        stall_request = 1'b1;
        send_random(350);

        write_null_pattern(pack_ts(1, 15, 5, 2000, 3600, 500));
        send_item(PART_DAY, pack_ts(1, 15, 5, 2000, 3600, 500));
        send_random(350);

        write_null_pattern({$urandom(), $urandom()});
        send_random(350);

        write_null_pattern('1);
        idling_on = 1'b0;
        send_random(350);
        s_valid <= 1'b0;

        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
